// ===== hw/rtl/tbp_pkg.sv =====
// Token bucket policer package: shared widths, codes, FSM state type and
// the command/status structs between controller and datapath.
// No dependencies.
package tbp_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned IDLE_W     = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned COUNT_O_W  = 7;
  localparam int unsigned RATE_FRAC  = 24;
  // room left in a bucket, in rate units, is always below 2^NEED_W
  localparam int unsigned NEED_W     = BURST_W + RATE_FRAC;
  localparam int unsigned CHUNK_W    = NEED_W / 2;
  localparam int unsigned PP_W       = CHUNK_W + RATE_W;
  localparam int unsigned ACC_W      = NEED_W + RATE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE  = 2'd0,
    CFG_BURST = 2'd1,
    CFG_IDLE  = 2'd2
  } tbp_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SWEEP,
    S_RESOLVE,
    S_FETCH,
    S_MUL_LO,
    S_MUL_HI,
    S_REFILL,
    S_UPDATE
  } tbp_state_e;

  typedef enum logic [1:0] {
    RESP_PASS,
    RESP_SWEEP,
    RESP_ALLOC,
    RESP_UPDATE
  } tbp_resp_e;

  typedef struct packed {
    logic      latch;
    logic      scan_en;
    logic      alloc_wr;
    logic      mul_lo;
    logic      mul_hi;
    logic      refill;
    logic      update_wr;
    logic      resp;
    tbp_resp_e resp_kind;
  } tbp_cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic bypass;
    logic scan_done;
    logic hit;
    logic free_found;
  } tbp_stat_t;

endpackage

// ===== hw/rtl/per_client_token_bucket_policer.sv =====
// Per-client token bucket policer, top level.
// Depends on tbp_pkg, tbp_ctrl, tbp_dpath (and tbp_ram below it).
//
// Usage:
//  - Command channel: drive opcode_i, client_key_i, key_present_i and
//    timestamp_i with start high; the word is taken on an edge where busy
//    is low. busy stays high until the result is issued.
//  - Result channel: done_o pulses for one cycle with allowed_o, tracked_o
//    and active_count_o. The receiver cannot stall; it must take the word.
//  - Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 rate,
//    1 burst, 2 idle limit) and cfg_data_i. Ready is always high; write
//    only while the block is idle.
//  - Sequence: a pass-through request is answered straight from decode. A
//    tracked request goes through decode, then scans the key RAM one entry
//    per cycle, stopping at the first hit. A miss answers from the resolve
//    step; a hit goes on through fetch, the two multiply steps, refill and
//    write-back. A sweep scans every entry and answers at its end.
//    The key, token and time RAMs each have a single read port, all read
//    at the same address; that port sets the scan rate.
//  - One word in flight at a time.
//  - Reset: all entries invalid, count zero, rate 0, burst 16, idle 0.
//    No clearing pass; the valid bits are flip-flops.
module per_client_token_bucket_policer #(
  parameter int unsigned ENTRIES         = 64,
  parameter int unsigned TIME_BITS       = 48,
  parameter int unsigned TOKEN_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode_i,
  input  logic [tbp_pkg::KEY_W-1:0]       client_key_i,
  input  logic                            key_present_i,
  input  logic [TIME_BITS-1:0]            timestamp_i,
  output logic                            done_o,
  output logic                            allowed_o,
  output logic                            tracked_o,
  output logic [tbp_pkg::COUNT_O_W-1:0]   active_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tbp_pkg::*;

  tbp_cmd_t  cmd;
  tbp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // controller: sequencing only
  tbp_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // datapath: table, arithmetic, result registers
  tbp_dpath #(
    .ENTRIES        (ENTRIES),
    .TIME_BITS      (TIME_BITS),
    .TOKEN_FRAC_BITS(TOKEN_FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .client_key_i  (client_key_i),
    .key_present_i (key_present_i),
    .timestamp_i   (timestamp_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .allowed_o     (allowed_o),
    .tracked_o     (tracked_o),
    .active_count_o(active_count_o)
  );

`ifndef NO_ASSERTIONS
  // every word ends with exactly one result strobe
  a_done_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("finish without result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word not processed");

  // an untracked denial is only ever a sweep result
  a_tracked_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !tracked_o && !allowed_o) |-> $past(stat.is_sweep))
    else $error("untracked denial outside a sweep");
`endif

endmodule

// ===== hw/rtl/tbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tbp_ctrl.sv =====
// Policer controller FSM: sequences scan, sweep, refill and write-back.
// Depends on tbp_pkg.
module tbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tbp_pkg::tbp_stat_t stat_i,
  output tbp_pkg::tbp_cmd_t  cmd_o
);
  import tbp_pkg::*;

  tbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (start) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.is_sweep) state_d = S_SWEEP;
        else if (stat_i.bypass) state_d = S_IDLE;
        else state_d = S_SCAN;
      end
      S_SCAN:    if (stat_i.scan_done) state_d = S_RESOLVE;
      S_SWEEP:   if (stat_i.scan_done) state_d = S_IDLE;
      S_RESOLVE: state_d = stat_i.hit ? S_FETCH : S_IDLE;
      S_FETCH:   state_d = S_MUL_LO;
      S_MUL_LO:  state_d = S_MUL_HI;
      S_MUL_HI:  state_d = S_REFILL;
      S_REFILL:  state_d = S_UPDATE;
      S_UPDATE:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.resp_kind = RESP_PASS;
    unique case (state_q)
      S_IDLE:  cmd_o.latch = start;
      S_CHECK: begin
        if (!stat_i.is_sweep && stat_i.bypass) begin
          cmd_o.resp = 1'b1;
        end
      end
      S_SCAN:  cmd_o.scan_en = 1'b1;
      S_SWEEP: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.resp      = 1'b1;
          cmd_o.resp_kind = RESP_SWEEP;
        end
      end
      S_RESOLVE: begin
        if (!stat_i.hit) begin
          cmd_o.resp = 1'b1;
          if (stat_i.free_found) begin
            cmd_o.alloc_wr  = 1'b1;
            cmd_o.resp_kind = RESP_ALLOC;
          end
        end
      end
      S_FETCH:  ;
      S_MUL_LO: cmd_o.mul_lo = 1'b1;
      S_MUL_HI: cmd_o.mul_hi = 1'b1;
      S_REFILL: cmd_o.refill = 1'b1;
      S_UPDATE: begin
        cmd_o.update_wr = 1'b1;
        cmd_o.resp      = 1'b1;
        cmd_o.resp_kind = RESP_UPDATE;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/tbp_dpath.sv =====
// Policer datapath: config registers, valid bits, bucket RAMs, scan
// pipeline, refill multiplier and result registers.
// Depends on tbp_pkg and tbp_ram.
module tbp_dpath #(
  parameter int unsigned ENTRIES         = 64,
  parameter int unsigned TIME_BITS       = 48,
  parameter int unsigned TOKEN_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                opcode_i,
  input  logic [tbp_pkg::KEY_W-1:0]           client_key_i,
  input  logic                                key_present_i,
  input  logic [TIME_BITS-1:0]                timestamp_i,
  input  tbp_pkg::tbp_cmd_t                   cmd_i,
  output tbp_pkg::tbp_stat_t                  stat_o,
  output logic                                done_o,
  output logic                                allowed_o,
  output logic                                tracked_o,
  output logic [tbp_pkg::COUNT_O_W-1:0]       active_count_o
);
  import tbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned SCN_W = IDX_W + 1;
  localparam int unsigned TOK_W = BURST_W + TOKEN_FRAC_BITS;
  localparam int unsigned SHIFT = RATE_FRAC - TOKEN_FRAC_BITS;

  // config
  logic [RATE_W-1:0]  rate_q;
  logic [BURST_W-1:0] burst_q;
  logic [IDLE_W-1:0]  idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      burst_q <= BURST_W'(16);
      idle_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
        CFG_BURST: burst_q <= cfg_data_i[BURST_W-1:0];
        CFG_IDLE:  idle_q  <= cfg_data_i[IDLE_W-1:0];
        default:   ;
      endcase
    end
  end

  // latched item
  logic                 op_q, present_q;
  logic [KEY_W-1:0]     key_q;
  logic [TIME_BITS-1:0] now_q;

  // scan control
  logic [SCN_W-1:0] scan_q, scan_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q, hit_d, free_q, free_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // RAM ports
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [KEY_W-1:0]     key_rd;
  logic [TOK_W-1:0]     tok_rd, tok_wr;
  logic [TIME_BITS-1:0] time_rd;
  logic                 tok_we;

  // arithmetic
  logic [TIME_BITS-1:0] elapsed_q, sweep_el;
  logic [TOK_W-1:0]     tok_q, cap, one;
  logic [NEED_W-1:0]    need_q;
  logic                 full_q, big, sat;
  logic [ACC_W-1:0]     acc_q;
  logic [63:0]          el64;
  logic [CHUNK_W-1:0]   mul_a;
  logic [PP_W-1:0]      pp;
  logic                 issue, expired, key_match;
  logic                 done_q, allowed_q, tracked_q, res_allowed, res_tracked;
  logic [COUNT_O_W-1:0] count_o_q;

  assign cap = {burst_q, {TOKEN_FRAC_BITS{1'b0}}};
  assign one = TOK_W'(1) << TOKEN_FRAC_BITS;

  assign issue   = cmd_i.scan_en && (scan_q != SCN_W'(ENTRIES));
  assign rd_addr = cmd_i.scan_en ? scan_q[IDX_W-1:0] : hit_idx_q;
  assign wr_addr = cmd_i.alloc_wr ? free_idx_q : hit_idx_q;

  assign sweep_el  = now_q - time_rd;
  assign expired   = 64'(sweep_el) > 64'(idle_q);
  assign key_match = valid_q[cmp_idx_q] && (key_rd == key_q);

  always_comb begin
    scan_d     = scan_q;
    cmp_vld_d  = issue;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    count_d    = count_q;
    if (cmd_i.latch) begin
      scan_d = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end
    if (issue) begin
      scan_d = scan_q + SCN_W'(1);
      if (!valid_q[scan_q[IDX_W-1:0]] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = scan_q[IDX_W-1:0];
      end
    end
    if (cmd_i.scan_en && cmp_vld_q) begin
      if (op_q) begin
        if (valid_q[cmp_idx_q] && expired) begin
          valid_d[cmp_idx_q] = 1'b0;
          count_d            = count_q - CNT_W'(1);
        end
      end else if (!hit_q && key_match) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
    end
    if (cmd_i.alloc_wr) begin
      valid_d[free_idx_q] = 1'b1;
      count_d             = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      done_q    <= cmd_i.resp;
    end
  end

  // refill: elapsed * rate in two partial products
  assign el64  = 64'(elapsed_q);
  assign big   = |el64[63:NEED_W];
  assign mul_a = cmd_i.mul_hi ? el64[NEED_W-1:CHUNK_W] : el64[CHUNK_W-1:0];
  assign pp    = PP_W'(mul_a) * PP_W'(rate_q);
  assign sat   = full_q || big || (acc_q > ACC_W'(need_q));

  always_comb begin
    tok_we = cmd_i.alloc_wr || cmd_i.update_wr;
    if (cmd_i.alloc_wr) begin
      tok_wr = (burst_q != '0) ? cap - one : cap;
    end else begin
      tok_wr = (tok_q >= one) ? tok_q - one : tok_q;
    end
  end

  always_comb begin
    unique case (cmd_i.resp_kind)
      RESP_PASS:   begin res_allowed = 1'b1;            res_tracked = 1'b0; end
      RESP_SWEEP:  begin res_allowed = 1'b0;            res_tracked = 1'b0; end
      RESP_ALLOC:  begin res_allowed = burst_q != '0;   res_tracked = 1'b1; end
      RESP_UPDATE: begin res_allowed = tok_q >= one;    res_tracked = 1'b1; end
      default:     begin res_allowed = 1'b0;            res_tracked = 1'b0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q      <= opcode_i;
      key_q     <= client_key_i;
      present_q <= key_present_i;
      now_q     <= timestamp_i;
    end
    cmp_idx_q  <= scan_q[IDX_W-1:0];
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (!cmd_i.scan_en && !cmd_i.mul_lo && !cmd_i.mul_hi && !cmd_i.refill
        && !cmd_i.update_wr && !cmd_i.resp && !cmd_i.latch && hit_q) begin
      elapsed_q <= now_q - time_rd;
      tok_q     <= tok_rd;
    end
    if (cmd_i.mul_lo) begin
      acc_q  <= ACC_W'(pp);
      full_q <= tok_q >= cap;
      need_q <= (tok_q >= cap) ? '0 : NEED_W'(cap - tok_q) << SHIFT;
    end
    if (cmd_i.mul_hi) begin
      acc_q <= acc_q + (ACC_W'(pp) << CHUNK_W);
    end
    if (cmd_i.refill) begin
      tok_q <= sat ? cap : tok_q + TOK_W'(acc_q >> SHIFT);
    end
    if (cmd_i.resp) begin
      allowed_q <= res_allowed;
      tracked_q <= res_tracked;
      count_o_q <= COUNT_O_W'(count_d);
    end
  end

  tbp_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.alloc_wr),
    .waddr_i(wr_addr),
    .wdata_i(key_q),
    .raddr_i(rd_addr),
    .rdata_o(key_rd)
  );

  tbp_ram #(.WIDTH(TOK_W), .DEPTH(ENTRIES)) u_tok_ram (
    .clk_i  (clk_i),
    .we_i   (tok_we),
    .waddr_i(wr_addr),
    .wdata_i(tok_wr),
    .raddr_i(rd_addr),
    .rdata_o(tok_rd)
  );

  tbp_ram #(.WIDTH(TIME_BITS), .DEPTH(ENTRIES)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (tok_we),
    .waddr_i(wr_addr),
    .wdata_i(now_q),
    .raddr_i(rd_addr),
    .rdata_o(time_rd)
  );

  assign stat_o.is_sweep   = op_q;
  assign stat_o.bypass     = (rate_q == '0) || !present_q;
  assign stat_o.scan_done  = hit_q || ((scan_q == SCN_W'(ENTRIES)) && !cmp_vld_q);
  assign stat_o.hit        = hit_q;
  assign stat_o.free_found = free_q;

  assign done_o         = done_q;
  assign allowed_o      = allowed_q;
  assign tracked_o      = tracked_q;
  assign active_count_o = count_o_q;

endmodule
